@@ src/psmpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmpc_pkg
// Shared types and constants for the ps/2 mouse packet cursor block.
// ----------------------------------------------------------------------------
package psmpc_pkg;

  localparam int unsigned PosBitsDefault = 10;
  localparam int unsigned CoordW         = 10;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 10;

  localparam logic [CoordW-1:0] XLimitReset = CoordW'(300);
  localparam logic [CoordW-1:0] YLimitReset = CoordW'(150);

  // first byte flags, third byte check bits
  localparam int unsigned FlagSyncBit  = 3;
  localparam int unsigned FlagXSignBit = 4;
  localparam int unsigned FlagYSignBit = 5;
  localparam int unsigned ChkBit6      = 6;
  localparam int unsigned ChkBit7      = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_X_LIMIT = 2'd1,
    CFG_Y_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_FLAGS = 3'b001,
    PH_DX    = 3'b010,
    PH_DY    = 3'b100
  } phase_e;

endpackage

@@ src/ps2_mouse_packet_cursor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// Frames ps/2 mouse bytes into three-byte packets and tracks a cursor.
// ----------------------------------------------------------------------------
// One mouse byte is taken per cycle. Every third byte of a framed packet
// that passes the check produces one beat with the clamped cursor position
// and a moving flag; other bytes produce nothing. The whole update is one
// add, a clamp and a compare between the byte input and the result register,
// so a byte is accepted in every cycle unless a finished result is stalled
// at the output. The first byte is resynced until its sync bit is set.
// Write limits and enable via the plain write port while idle; unchecked.
module ps2_mouse_packet_cursor
  import psmpc_pkg::*;
#(
  parameter int unsigned POS_BITS = PosBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CoordW-1:0]   cursor_x_o,
  output logic [CoordW-1:0]   cursor_y_o,
  output logic                moving_o
);

  localparam int unsigned SumW = POS_BITS + 2;
  localparam int unsigned CmpW = (POS_BITS > CoordW) ? POS_BITS : CoordW;

  logic                enable_q;
  logic [CoordW-1:0]   x_limit_q, y_limit_q;
  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    flag_q, flag_d;
  logic [ByteW-1:0]    dx_q, dx_d;
  logic [POS_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                out_valid_q, out_valid_d;
  logic [CoordW-1:0]   cur_x_q, cur_y_q;
  logic                moving_q;

  logic                in_fire, emit;
  logic [SumW-1:0]     dx_ext, dy_ext, x_sum, y_diff, x_adj, y_adj;
  logic [POS_BITS-1:0] x_wrap, y_wrap, x_lo, y_lo, nx, ny;
  logic [CmpW-1:0]     x_ext, y_ext, xl_ext, yl_ext, nx_ext, ny_ext;
  logic                x_le0, y_le0, moved;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // config register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      x_limit_q <= XLimitReset;
      y_limit_q <= YLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        CFG_X_LIMIT: x_limit_q <= cfg_wdata_i[CoordW-1:0];
        CFG_Y_LIMIT: y_limit_q <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // position update datapath
  always_comb begin
    dx_ext = {{(SumW-ByteW){dx_q[ByteW-1]}}, dx_q};
    dy_ext = {{(SumW-ByteW){rx_byte_i[ByteW-1]}}, rx_byte_i};
    x_sum  = {2'b00, pos_x_q} + dx_ext;
    y_diff = {2'b00, pos_y_q} - dy_ext;
    x_le0  = x_sum[SumW-1] || (x_sum == '0);
    y_le0  = y_diff[SumW-1] || (y_diff == '0);
    x_adj  = (flag_q[FlagXSignBit] && x_le0) ? '0 : x_sum;
    y_adj  = (!flag_q[FlagYSignBit] && y_le0) ? '0 : y_diff;
    x_wrap = x_adj[POS_BITS-1:0];
    y_wrap = y_adj[POS_BITS-1:0];
    x_lo   = (x_wrap == '0) ? POS_BITS'(1) : x_wrap;
    y_lo   = (y_wrap == '0) ? POS_BITS'(1) : y_wrap;
    x_ext  = CmpW'(x_lo);
    y_ext  = CmpW'(y_lo);
    xl_ext = CmpW'(x_limit_q);
    yl_ext = CmpW'(y_limit_q);
    nx_ext = (x_ext > xl_ext) ? xl_ext : x_ext;
    ny_ext = (y_ext > yl_ext) ? yl_ext : y_ext;
    nx     = nx_ext[POS_BITS-1:0];
    ny     = ny_ext[POS_BITS-1:0];
    moved  = (nx != pos_x_q) || (ny != pos_y_q);
  end

  // packet framer
  always_comb begin
    phase_d     = phase_q;
    flag_d      = flag_q;
    dx_d        = dx_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    emit        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire && enable_q) begin
      case (phase_q)
        PH_FLAGS: begin
          flag_d = rx_byte_i;
          if (rx_byte_i[FlagSyncBit]) phase_d = PH_DX;
        end
        PH_DX: begin
          dx_d    = rx_byte_i;
          phase_d = PH_DY;
        end
        PH_DY: begin
          phase_d = PH_FLAGS;
          if (rx_byte_i[ChkBit7] || !rx_byte_i[ChkBit6]) begin
            emit        = 1'b1;
            pos_x_d     = nx;
            pos_y_d     = ny;
            out_valid_d = 1'b1;
          end
        end
        default: phase_d = PH_FLAGS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FLAGS;
      flag_q      <= '0;
      dx_q        <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      flag_q      <= flag_d;
      dx_q        <= dx_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
      if (emit) moving_q <= moved;
    end
  end

  // result payload, low coordinate bits
  always_ff @(posedge clk_i) begin
    if (emit) begin
      cur_x_q <= nx_ext[CoordW-1:0];
      cur_y_q <= ny_ext[CoordW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_x_o  = cur_x_q;
  assign cursor_y_o  = cur_y_q;
  assign moving_o    = moving_q;

endmodule
